// ----- sv/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, branch codes and payload types of the rotation matrix to
// quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

	// field and term widths
	localparam int unsigned FIELD_W    = 18;
	localparam int unsigned TERM_W     = 20;
	localparam int unsigned MAG_W      = TERM_W - 1;
	localparam int unsigned SQ_W       = 2 * MAG_W;
	localparam int unsigned SUM_W      = SQ_W + 2;
	localparam int unsigned LANES      = 4;

	// square root datapath: radicand is the sum of squares with 20 fraction bits
	localparam int unsigned RAD_SH     = 20;
	localparam int unsigned RAD_W      = SUM_W + RAD_SH;
	localparam int unsigned ROOT_W     = RAD_W / 2;
	localparam int unsigned REM_W      = ROOT_W + 2;
	localparam int unsigned SQRT_STEPS = ROOT_W;

	// divider datapath: numerator is |term| * 2^26 + root / 2
	localparam int unsigned SCALE_SH   = 26;
	localparam int unsigned NUM_W      = MAG_W + SCALE_SH + 1;
	localparam int unsigned QUO_W      = 17;
	localparam int unsigned DIV_STEPS  = QUO_W;

	localparam logic signed [TERM_W-1:0] ONE_Q16 = 20'sd65536;
	localparam logic [QUO_W-1:0]         Q_MAX   = 17'd65536;

	// branch codes: which of trace, m00, m11, m22 is largest
	localparam logic [1:0] BR_T = 2'd0;
	localparam logic [1:0] BR_X = 2'd1;
	localparam logic [1:0] BR_Y = 2'd2;
	localparam logic [1:0] BR_Z = 2'd3;

	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [TERM_W-1:0]  term_t;

	typedef struct packed {
		term_t a;
		term_t b;
		term_t c;
		term_t d;
		logic  zero;
	} terms_t;

endpackage

// ----- sv/rmq_ifs.sv -----
// ----------------------------------------------------------------------------
// rmq_ifs
// Valid/ready channels of the unit: one matrix beat in, one quaternion beat
// out.
// ----------------------------------------------------------------------------
interface rmq_mat_if import rmq_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t m00;
	field_t m01;
	field_t m02;
	field_t m10;
	field_t m11;
	field_t m12;
	field_t m20;
	field_t m21;
	field_t m22;

	modport source (output valid, output m00, output m01, output m02, output m10,
		output m11, output m12, output m20, output m21, output m22, input ready);
	modport sink (input valid, input m00, input m01, input m02, input m10,
		input m11, input m12, input m20, input m21, input m22, output ready);
endinterface

interface rmq_quat_if import rmq_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t qx;
	field_t qy;
	field_t qz;
	field_t qw;

	modport source (output valid, output qx, output qy, output qz, output qw,
		input ready);
	modport sink (input valid, input qx, input qy, input qz, input qw,
		output ready);
endinterface

// ----- sv/rmq_isqrt.sv -----
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined integer square root of sum * 2^20, one root bit per stage, with
// the branch terms carried alongside.
// ----------------------------------------------------------------------------
module rmq_isqrt import rmq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SUM_W-1:0]  sum,
	input  terms_t            in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROOT_W-1:0] root,
	output terms_t            out_side
);

	logic [SQRT_STEPS-1:0] v_s;
	logic [SQRT_STEPS:0]   go;
	logic [REM_W-1:0]      rem_s   [SQRT_STEPS];
	logic [ROOT_W-1:0]     root_s  [SQRT_STEPS];
	logic [RAD_W-1:0]      rad_s   [SQRT_STEPS];
	terms_t                side_s  [SQRT_STEPS];

	logic                  v_in    [SQRT_STEPS];
	logic [REM_W-1:0]      rem_in  [SQRT_STEPS];
	logic [ROOT_W-1:0]     root_in [SQRT_STEPS];
	logic [RAD_W-1:0]      rad_in  [SQRT_STEPS];
	terms_t                side_in [SQRT_STEPS];
	logic [REM_W-1:0]      cur_w   [SQRT_STEPS];
	logic [REM_W-1:0]      trial_w [SQRT_STEPS];
	logic                  ge_w    [SQRT_STEPS];
	logic [REM_W-1:0]      rem_nx  [SQRT_STEPS];
	logic [ROOT_W-1:0]     root_nx [SQRT_STEPS];
	logic [RAD_W-1:0]      rad_nx  [SQRT_STEPS];

	// advance a stage when it is empty or the next one advances
	always_comb begin
		go[SQRT_STEPS] = out_ready;
		for (int k = SQRT_STEPS - 1; k >= 0; k--) begin
			go[k] = !v_s[k] || go[k + 1];
		end
	end

	assign in_ready  = go[0];
	assign out_valid = v_s[SQRT_STEPS-1];
	assign root      = root_s[SQRT_STEPS-1];
	assign out_side  = side_s[SQRT_STEPS-1];

	// stage sources
	always_comb begin
		v_in[0]    = in_valid;
		rem_in[0]  = '0;
		root_in[0] = '0;
		rad_in[0]  = {sum, {RAD_SH{1'b0}}};
		side_in[0] = in_side;
		for (int k = 1; k < SQRT_STEPS; k++) begin
			v_in[k]    = v_s[k-1];
			rem_in[k]  = rem_s[k-1];
			root_in[k] = root_s[k-1];
			rad_in[k]  = rad_s[k-1];
			side_in[k] = side_s[k-1];
		end
	end

	// one root digit per stage: bring down two radicand bits, try 4r+1
	always_comb begin
		for (int k = 0; k < SQRT_STEPS; k++) begin
			cur_w[k]   = {rem_in[k][REM_W-3:0], rad_in[k][RAD_W-1 -: 2]};
			trial_w[k] = {root_in[k], 2'b01};
			ge_w[k]    = cur_w[k] >= trial_w[k];
			rem_nx[k]  = ge_w[k] ? (cur_w[k] - trial_w[k]) : cur_w[k];
			root_nx[k] = {root_in[k][ROOT_W-2:0], ge_w[k]};
			rad_nx[k]  = rad_in[k] << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 0; k < SQRT_STEPS; k++) begin
				if (go[k]) begin
					v_s[k] <= v_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SQRT_STEPS; k++) begin
			if (go[k]) begin
				rem_s[k]  <= rem_nx[k];
				root_s[k] <= root_nx[k];
				rad_s[k]  <= rad_nx[k];
				side_s[k] <= side_in[k];
			end
		end
	end

`ifndef ASSERT_OFF
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[SQRT_STEPS-1] |-> (rem_s[SQRT_STEPS-1] <= {1'b0, root_s[SQRT_STEPS-1], 1'b0}))
		else $error("square root remainder exceeds 2*root");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s[0] && !out_ready))
		else $error("root pipe refuses input without a stall");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(go[1] && v_s[0]) |=> v_s[1])
		else $error("root pipe dropped a beat");
`endif

endmodule

// ----- sv/rmq_div.sv -----
// ----------------------------------------------------------------------------
// rmq_div
// Four-lane pipelined restoring divider: |term| * 2^26 / root rounded to
// nearest, one quotient bit per stage, then saturate, sign and zero override.
// ----------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ROOT_W-1:0] root,
	input  terms_t            in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output field_t            qx,
	output field_t            qy,
	output field_t            qz,
	output field_t            qw
);

	localparam int unsigned NST = DIV_STEPS + 1;

	logic [NST-1:0]    v_s;
	logic [NST:0]      go;
	logic [ROOT_W-1:0] root_s [NST];
	logic              zero_s [NST];
	logic [ROOT_W-1:0] rem_s  [NST][LANES];
	logic [QUO_W-1:0]  low_s  [NST][LANES];
	logic [QUO_W-1:0]  quo_s  [NST][LANES];
	logic              ovf_s  [NST][LANES];
	logic              neg_s  [NST][LANES];

	term_t             term_w [LANES];
	logic [MAG_W-1:0]  mag_w  [LANES];
	logic [NUM_W-1:0]  num_w  [LANES];
	logic [ROOT_W:0]   cur_w  [NST][LANES];
	logic              ge_w   [NST][LANES];
	logic [QUO_W-1:0]  qm_w   [LANES];
	field_t            res_w  [LANES];

	logic              v_o;
	field_t            q_o    [LANES];

	always_comb begin
		go[NST] = !v_o || out_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			go[k] = !v_s[k] || go[k + 1];
		end
	end

	assign in_ready  = go[0];
	assign out_valid = v_o;
	assign qx        = q_o[0];
	assign qy        = q_o[1];
	assign qz        = q_o[2];
	assign qw        = q_o[3];

	// prepare numerators and catch quotients beyond the kept bits
	always_comb begin
		term_w[0] = in_side.a;
		term_w[1] = in_side.b;
		term_w[2] = in_side.c;
		term_w[3] = in_side.d;
		for (int l = 0; l < LANES; l++) begin
			mag_w[l] = term_w[l][TERM_W-1] ? MAG_W'(-term_w[l]) : MAG_W'(term_w[l]);
			num_w[l] = (NUM_W'(mag_w[l]) << SCALE_SH) + NUM_W'(root >> 1);
		end
	end

	// one quotient bit per stage
	always_comb begin
		for (int k = 1; k < NST; k++) begin
			for (int l = 0; l < LANES; l++) begin
				cur_w[k][l] = {rem_s[k-1][l], low_s[k-1][l][QUO_W-1]};
				ge_w[k][l]  = cur_w[k][l] >= {1'b0, root_s[k-1]};
			end
		end
		for (int l = 0; l < LANES; l++) begin
			cur_w[0][l] = '0;
			ge_w[0][l]  = 1'b0;
		end
	end

	// saturate, sign and zero override of the last stage
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			qm_w[l] = (ovf_s[NST-1][l] || quo_s[NST-1][l] > Q_MAX) ? Q_MAX
				: quo_s[NST-1][l];
			if (zero_s[NST-1]) begin
				res_w[l] = '0;
			end else if (neg_s[NST-1][l]) begin
				res_w[l] = -FIELD_W'(qm_w[l]);
			end else begin
				res_w[l] = FIELD_W'(qm_w[l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
			v_o <= 1'b0;
		end else begin
			if (go[0]) begin
				v_s[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (go[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
			if (go[NST]) begin
				v_o <= v_s[NST-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go[0]) begin
			root_s[0] <= root;
			zero_s[0] <= in_side.zero;
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= ROOT_W'(num_w[l][NUM_W-1:QUO_W]);
				low_s[0][l] <= num_w[l][QUO_W-1:0];
				quo_s[0][l] <= '0;
				ovf_s[0][l] <= ROOT_W'(num_w[l][NUM_W-1:QUO_W]) >= root;
				neg_s[0][l] <= term_w[l][TERM_W-1];
			end
		end
		for (int k = 1; k < NST; k++) begin
			if (go[k]) begin
				root_s[k] <= root_s[k-1];
				zero_s[k] <= zero_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					rem_s[k][l] <= ge_w[k][l] ? ROOT_W'(cur_w[k][l] - {1'b0, root_s[k-1]})
						: ROOT_W'(cur_w[k][l]);
					low_s[k][l] <= low_s[k-1][l] << 1;
					quo_s[k][l] <= {quo_s[k-1][l][QUO_W-2:0], ge_w[k][l]};
					ovf_s[k][l] <= ovf_s[k-1][l];
					neg_s[k][l] <= neg_s[k-1][l];
				end
			end
		end
		if (go[NST]) begin
			for (int l = 0; l < LANES; l++) begin
				q_o[l] <= res_w[l];
			end
		end
	end

`ifndef ASSERT_OFF
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_o |-> (q_o[0] <= 18'sd65536 && q_o[0] >= -18'sd65536
			&& q_o[3] <= 18'sd65536 && q_o[3] >= -18'sd65536))
		else $error("quaternion component outside unit range");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(go[NST] && v_s[NST-1] && zero_s[NST-1]) |=>
		(q_o[0] == '0 && q_o[1] == '0 && q_o[2] == '0 && q_o[3] == '0))
		else $error("zero sum did not give a zero quaternion");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(go[NST] && v_s[NST-1]) |=> v_o)
		else $error("divider dropped a beat");
`endif

endmodule

// ----- sv/rotation_matrix_to_quaternion_unit.sv -----
// A matrix beat passes 4 front stages, 30 square root stages, 1 divider setup
// stage, 17 divider stages and 1 output register on its way to its quaternion
// beat. Throughput: one beat per cycle while quat.ready does not hold the
// pipe, as each stage retires one root bit or one quotient bit. Reset clears
// only the stage valid bits; the datapath registers hold whatever they last loaded.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Shepperd conversion of a Q1.16 rotation matrix to a unit quaternion:
// branch pick, branch terms, sum of squares, square root, scaled division.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rmq_mat_if.sink    mat,
	rmq_quat_if.source quat
);

	// stage 1: matrix, trace, branch
	logic             v_s1, v_s2, v_s3, v_s4;
	logic             go_s1, go_s2, go_s3, go_s4;
	term_t            x00_s1, x01_s1, x02_s1, x10_s1, x11_s1;
	term_t            x12_s1, x20_s1, x21_s1, x22_s1;
	term_t            t_s1;
	logic [1:0]       br_s1;
	terms_t           terms_s2, terms_s3, terms_s4;
	logic [SQ_W-1:0]  sq_s3 [LANES];
	logic [SUM_W-1:0] sum_s4;

	term_t            e00, e11, e22, t_w;
	logic [1:0]       br_w;
	terms_t           terms_w;
	term_t            tm_w [LANES];
	logic [MAG_W-1:0] mag_w [LANES];
	logic [SUM_W-1:0] sum_w;

	logic             sq_ready;
	logic             dv_valid, dv_ready;
	logic [ROOT_W-1:0] dv_root;
	terms_t           dv_side;

	// advance a front stage when it is empty or the next one advances
	assign go_s4     = !v_s4 || sq_ready;
	assign go_s3     = !v_s3 || go_s4;
	assign go_s2     = !v_s2 || go_s3;
	assign go_s1     = !v_s1 || go_s2;
	assign mat.ready = go_s1;

	// trace and branch pick, ties to the first in order
	always_comb begin
		e00 = TERM_W'(mat.m00);
		e11 = TERM_W'(mat.m11);
		e22 = TERM_W'(mat.m22);
		t_w = e00 + e11 + e22;
		if (t_w >= e00 && t_w >= e11 && t_w >= e22) begin
			br_w = BR_T;
		end else if (e00 >= e11 && e00 >= e22) begin
			br_w = BR_X;
		end else if (e11 >= e22) begin
			br_w = BR_Y;
		end else begin
			br_w = BR_Z;
		end
	end

	// branch sums and differences
	always_comb begin
		terms_w.zero = 1'b0;
		case (br_s1)
			BR_T: begin
				terms_w.a = x21_s1 - x12_s1;
				terms_w.b = x02_s1 - x20_s1;
				terms_w.c = x10_s1 - x01_s1;
				terms_w.d = ONE_Q16 + t_s1;
			end
			BR_X: begin
				terms_w.a = ONE_Q16 - t_s1 + (x00_s1 <<< 1);
				terms_w.b = x01_s1 + x10_s1;
				terms_w.c = x02_s1 + x20_s1;
				terms_w.d = x21_s1 - x12_s1;
			end
			BR_Y: begin
				terms_w.a = x01_s1 + x10_s1;
				terms_w.b = ONE_Q16 - t_s1 + (x11_s1 <<< 1);
				terms_w.c = x12_s1 + x21_s1;
				terms_w.d = x02_s1 - x20_s1;
			end
			default: begin
				terms_w.a = x02_s1 + x20_s1;
				terms_w.b = x12_s1 + x21_s1;
				terms_w.c = ONE_Q16 - t_s1 + (x22_s1 <<< 1);
				terms_w.d = x10_s1 - x01_s1;
			end
		endcase
	end

	// magnitudes for squaring
	always_comb begin
		tm_w[0] = terms_s2.a;
		tm_w[1] = terms_s2.b;
		tm_w[2] = terms_s2.c;
		tm_w[3] = terms_s2.d;
		for (int l = 0; l < LANES; l++) begin
			mag_w[l] = tm_w[l][TERM_W-1] ? MAG_W'(-tm_w[l]) : MAG_W'(tm_w[l]);
		end
	end

	// sum of squares
	assign sum_w = SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2])
		+ SUM_W'(sq_s3[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (go_s1) begin
				v_s1 <= mat.valid;
			end
			if (go_s2) begin
				v_s2 <= v_s1;
			end
			if (go_s3) begin
				v_s3 <= v_s2;
			end
			if (go_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			x00_s1 <= e00;
			x01_s1 <= TERM_W'(mat.m01);
			x02_s1 <= TERM_W'(mat.m02);
			x10_s1 <= TERM_W'(mat.m10);
			x11_s1 <= e11;
			x12_s1 <= TERM_W'(mat.m12);
			x20_s1 <= TERM_W'(mat.m20);
			x21_s1 <= TERM_W'(mat.m21);
			x22_s1 <= e22;
			t_s1   <= t_w;
			br_s1  <= br_w;
		end
		if (go_s2) begin
			terms_s2 <= terms_w;
		end
		if (go_s3) begin
			terms_s3 <= terms_s2;
			for (int l = 0; l < LANES; l++) begin
				sq_s3[l] <= SQ_W'(mag_w[l]) * SQ_W'(mag_w[l]);
			end
		end
		if (go_s4) begin
			sum_s4   <= sum_w;
			terms_s4 <= {terms_s3.a, terms_s3.b, terms_s3.c, terms_s3.d, (sum_w == '0)};
		end
	end

	rmq_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (sq_ready),
		.sum       (sum_s4),
		.in_side   (terms_s4),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.root      (dv_root),
		.out_side  (dv_side)
	);

	rmq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_ready  (dv_ready),
		.root      (dv_root),
		.in_side   (dv_side),
		.out_valid (quat.valid),
		.out_ready (quat.ready),
		.qx        (quat.qx),
		.qy        (quat.qy),
		.qz        (quat.qz),
		.qw        (quat.qw)
	);

`ifndef ASSERT_OFF
	a_zero_terms: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && terms_s4.zero) |->
		(terms_s4.a == '0 && terms_s4.b == '0 && terms_s4.c == '0 && terms_s4.d == '0))
		else $error("zero sum of squares with a nonzero term");
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		!mat.ready |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input refused while the front pipe has a bubble");
	a_front_move: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s2 && v_s1) |=> v_s2)
		else $error("front pipe dropped a beat");
`endif

endmodule
